>>> rtl/kahw_pkg.sv
// ----------------------------------------------------------------------------
// kahw_pkg
// Types and constants shared by the keepalive handshake watchdog modules.
// ----------------------------------------------------------------------------
package kahw_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PERIOD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_PULSE      = 3'd4;

  localparam logic [15:0] RESPONSE_TIMEOUT_RST = 16'd500;
  localparam logic [15:0] POLL_INTERVAL_RST    = 16'd50;
  localparam logic [23:0] CHECK_PERIOD_RST     = 24'd1000;
  localparam logic [15:0] MISS_LIMIT_RST       = 16'd3;
  localparam logic [15:0] RESET_PULSE_RST      = 16'd100;

  typedef enum logic [3:0] {
    PH_LOW   = 4'b0001,
    PH_HIGH  = 4'b0010,
    PH_PULSE = 4'b0100,
    PH_WAIT  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [15:0] response_timeout_ticks;
    logic [15:0] poll_interval_ticks;
    logic [23:0] check_period_ticks;
    logic [15:0] miss_limit;
    logic [15:0] reset_pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic        keepalive_drive;
    logic        partner_reset_n;
    logic [15:0] miss_count;
    logic        reset_event;
  } result_t;

endpackage

>>> rtl/kahw_tick_if.sv
// ----------------------------------------------------------------------------
// kahw_tick_if
// Tick channel: one transaction per timer tick with the sampled partner level.
// ----------------------------------------------------------------------------
interface kahw_tick_if;
  logic valid;
  logic ready;
  logic partner_level;

  modport source (output valid, output partner_level, input ready);
  modport sink (input valid, input partner_level, output ready);
endinterface

>>> rtl/kahw_status_if.sv
// ----------------------------------------------------------------------------
// kahw_status_if
// Status channel: one transaction per tick with the watchdog outputs.
// ----------------------------------------------------------------------------
interface kahw_status_if;
  logic        valid;
  logic        ready;
  logic        keepalive_drive;
  logic        partner_reset_n;
  logic [15:0] miss_count;
  logic        reset_event;

  modport source (
    output valid, output keepalive_drive, output partner_reset_n,
    output miss_count, output reset_event, input ready
  );
  modport sink (
    input valid, input keepalive_drive, input partner_reset_n,
    input miss_count, input reset_event, output ready
  );
endinterface

>>> rtl/kahw_cfg.sv
// ----------------------------------------------------------------------------
// kahw_cfg
// Configuration register file with index decode and reset defaults.
// ----------------------------------------------------------------------------
module kahw_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [kahw_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [kahw_pkg::CFG_DATA_W-1:0] wr_data,
  output kahw_pkg::cfg_t                  cfg
);
  import kahw_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.response_timeout_ticks <= RESPONSE_TIMEOUT_RST;
      cfg.poll_interval_ticks    <= POLL_INTERVAL_RST;
      cfg.check_period_ticks     <= CHECK_PERIOD_RST;
      cfg.miss_limit             <= MISS_LIMIT_RST;
      cfg.reset_pulse_ticks      <= RESET_PULSE_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_RESPONSE_TIMEOUT: cfg.response_timeout_ticks <= wr_data[15:0];
        CFG_POLL_INTERVAL:    cfg.poll_interval_ticks    <= wr_data[15:0];
        CFG_CHECK_PERIOD:     cfg.check_period_ticks     <= wr_data[23:0];
        CFG_MISS_LIMIT:       cfg.miss_limit             <= wr_data[15:0];
        CFG_RESET_PULSE:      cfg.reset_pulse_ticks      <= wr_data[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/kahw_in_reg.sv
// ----------------------------------------------------------------------------
// kahw_in_reg
// Input register for the tick channel.
// ----------------------------------------------------------------------------
module kahw_in_reg (
  input  logic       clk,
  input  logic       rst,
  kahw_tick_if.sink  tick,
  input  logic       take,
  output logic       valid,
  output logic       level
);

  assign tick.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (tick.ready) begin
      valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      level <= tick.partner_level;
    end
  end

endmodule

>>> rtl/kahw_fsm.sv
// ----------------------------------------------------------------------------
// kahw_fsm
// Watchdog state and the per-tick phase evaluation.
// ----------------------------------------------------------------------------
module kahw_fsm (
  input  logic              clk,
  input  logic              rst,
  input  kahw_pkg::cfg_t    cfg,
  input  logic              fire,
  input  logic              level,
  output kahw_pkg::result_t res
);
  import kahw_pkg::*;

  // A tick can pass through at most seven phase changes.
  localparam int CHAIN_STEPS = 7;

  typedef struct packed {
    phase_t      phase;
    logic        fresh;
    logic [15:0] poll_left;
    logic        answered_low;
    logic [15:0] misses;
    logic        drive;
    logic        rline;
    logic        flagged;
    logic        started;
    logic        stop;
  } ch_t;

  phase_t      phase;
  logic [15:0] elapsed;
  logic [15:0] poll_left;
  logic [31:0] period;
  logic        answered_low;
  logic [15:0] misses;
  logic        drive;
  logic        rline;

  logic        t_hit0;
  logic        r_hit0;
  logic        tz;
  logic        rz;
  logic        period_hit;
  logic [15:0] reload;
  logic [31:0] period_base;
  logic [15:0] elapsed_next;
  logic [15:0] poll_left_next;
  logic [31:0] period_next;
  ch_t         chain [CHAIN_STEPS+1];
  ch_t         fin;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic ch_t enter(input ch_t s, input phase_t p);
    ch_t n;
    n = s;
    n.phase = p;
    n.fresh = 1'b1;
    n.poll_left = '0;
    return n;
  endfunction

  function automatic ch_t step(
    input ch_t         s,
    input logic        lvl,
    input logic        th0,
    input logic        rh0,
    input logic        t_zero,
    input logic        r_zero,
    input logic        p_hit,
    input logic [15:0] rld,
    input logic [15:0] limit
  );
    ch_t  n;
    logic hit;
    logic judge;
    n = s;
    hit = 1'b0;
    judge = 1'b0;
    if (!s.stop) begin
      case (s.phase)
        PH_LOW, PH_HIGH: begin
          n.drive = (s.phase == PH_HIGH);
          hit = s.fresh ? t_zero : th0;
          if (s.poll_left != '0) begin
            n.stop = 1'b1;
          end else if (hit) begin
            if (s.phase == PH_LOW) begin
              n.answered_low = 1'b0;
              n = enter(n, PH_HIGH);
            end else begin
              n.misses = sat_inc16(s.misses);
              judge = 1'b1;
            end
          end else if (s.phase == PH_LOW && !lvl) begin
            n.answered_low = 1'b1;
            n = enter(n, PH_HIGH);
          end else if (s.phase == PH_HIGH && lvl) begin
            n.misses = s.answered_low ? 16'd0 : sat_inc16(s.misses);
            judge = 1'b1;
          end else begin
            n.poll_left = rld;
            n.stop = 1'b1;
          end
        end
        PH_PULSE: begin
          hit = s.fresh ? r_zero : rh0;
          if (hit) begin
            n.rline = 1'b1;
            n.misses = '0;
            n = enter(n, PH_WAIT);
          end else begin
            n.stop = 1'b1;
          end
        end
        PH_WAIT: begin
          if (s.started || !p_hit) begin
            n.stop = 1'b1;
          end else begin
            n.started = 1'b1;
            n = enter(n, PH_LOW);
          end
        end
        default: begin
          n.stop = 1'b1;
        end
      endcase
      if (judge) begin
        if (n.misses >= limit) begin
          n.rline = 1'b0;
          n.flagged = 1'b1;
          n = enter(n, PH_PULSE);
        end else begin
          n = enter(n, PH_WAIT);
        end
      end
    end
    return n;
  endfunction

  assign t_hit0     = (elapsed >= cfg.response_timeout_ticks);
  assign r_hit0     = (elapsed >= cfg.reset_pulse_ticks);
  assign tz         = (cfg.response_timeout_ticks == '0);
  assign rz         = (cfg.reset_pulse_ticks == '0);
  assign period_hit = (period >= {8'd0, cfg.check_period_ticks});
  assign reload     = (cfg.poll_interval_ticks == '0) ? 16'd1 : cfg.poll_interval_ticks;

  always_comb begin
    chain[0].phase        = phase;
    chain[0].fresh        = 1'b0;
    chain[0].poll_left    = poll_left;
    chain[0].answered_low = answered_low;
    chain[0].misses       = misses;
    chain[0].drive        = drive;
    chain[0].rline        = rline;
    chain[0].flagged      = 1'b0;
    chain[0].started      = 1'b0;
    chain[0].stop         = 1'b0;
    for (int i = 0; i < CHAIN_STEPS; i++) begin
      chain[i+1] = step(chain[i], level, t_hit0, r_hit0, tz, rz, period_hit, reload,
                        cfg.miss_limit);
    end
  end

  assign fin = chain[CHAIN_STEPS];

  assign elapsed_next   = fin.fresh ? 16'd1 : sat_inc16(elapsed);
  assign poll_left_next = (fin.poll_left != '0) ? fin.poll_left - 16'd1 : fin.poll_left;
  assign period_base    = fin.started ? period - {8'd0, cfg.check_period_ticks} : period;
  assign period_next    = (period_base == '1) ? period_base : period_base + 32'd1;

  assign res.keepalive_drive = fin.drive;
  assign res.partner_reset_n = fin.rline;
  assign res.miss_count      = fin.misses;
  assign res.reset_event     = fin.flagged;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LOW;
      elapsed      <= '0;
      poll_left    <= '0;
      period       <= '0;
      answered_low <= 1'b0;
      misses       <= '0;
      drive        <= 1'b0;
      rline        <= 1'b1;
    end else if (fire) begin
      phase        <= fin.phase;
      elapsed      <= elapsed_next;
      poll_left    <= poll_left_next;
      period       <= period_next;
      answered_low <= fin.answered_low;
      misses       <= fin.misses;
      drive        <= fin.drive;
      rline        <= fin.rline;
    end
  end

endmodule

>>> rtl/kahw_out_reg.sv
// ----------------------------------------------------------------------------
// kahw_out_reg
// Result register driving the status channel.
// ----------------------------------------------------------------------------
module kahw_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  kahw_pkg::result_t   res,
  output logic                can_load,
  kahw_status_if.source       status
);
  import kahw_pkg::*;

  result_t held;

  assign can_load = !status.valid || status.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      status.valid <= 1'b0;
    end else if (can_load) begin
      status.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= res;
    end
  end

  assign status.keepalive_drive = held.keepalive_drive;
  assign status.partner_reset_n = held.partner_reset_n;
  assign status.miss_count      = held.miss_count;
  assign status.reset_event     = held.reset_event;

endmodule

>>> rtl/keepalive_handshake_watchdog.sv
// ----------------------------------------------------------------------------
// keepalive_handshake_watchdog
// Handshake watchdog that checks a partner over a keepalive line pair.
// ----------------------------------------------------------------------------
// Each tick transaction carries one sample of the partner line and yields one
// status transaction with the keepalive drive level, the partner reset line,
// the miss count and a reset event flag. The block takes one transaction per
// clock while the status channel is not stalled; a tick passes through an
// input register and a result register before its status appears. All phase
// changes that a tick causes are evaluated combinationally between those two
// registers. Configuration writes are meant for idle periods only.
module keepalive_handshake_watchdog (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [kahw_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [kahw_pkg::CFG_DATA_W-1:0] wr_data,
  kahw_tick_if.sink                       tick,
  kahw_status_if.source                   status
);
  import kahw_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    s1_valid;
  logic    s1_level;
  logic    can_load;
  logic    fire;

  assign fire = s1_valid && can_load;

  kahw_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  kahw_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick),
    .take  (fire),
    .valid (s1_valid),
    .level (s1_level)
  );

  kahw_fsm u_fsm (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .fire  (fire),
    .level (s1_level),
    .res   (res)
  );

  kahw_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .res      (res),
    .can_load (can_load),
    .status   (status)
  );

endmodule
